/* hw/rtl/premultiplied_pixel_converter_unit_assert.svh */
// assertion macros shared by the checker
`ifndef PREMULTIPLIED_PIXEL_CONVERTER_UNIT_ASSERT_SVH
`define PREMULTIPLIED_PIXEL_CONVERTER_UNIT_ASSERT_SVH

// condition now implies consequence in the next cycle
`define PPC_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("ppc assertion failed");

// condition now implies consequence in the same cycle
`define PPC_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("ppc assertion failed");

`endif

/* hw/rtl/ppc_pkg.sv */
package ppc_pkg;

	localparam int FRAC_BITS   = 15;
	localparam int ONE_FIX     = 1 << FRAC_BITS;
	localparam int NUM_CELLS   = 16;
	localparam int AUX_W       = 25;
	localparam int BYTE_MAX    = 255;
	localparam int RECIP_255   = 8421505;
	localparam int RECIP_SHIFT = 31;

	typedef enum logic [2:0] {
		MODE_ARGB8  = 3'd0,
		MODE_RGBA8  = 3'd1,
		MODE_RGB8   = 3'd2,
		MODE_PREMUL = 3'd3,
		MODE_WIDEN  = 3'd4,
		MODE_PAD    = 3'd5,
		MODE_BLEND  = 3'd6,
		MODE_NONE   = 3'd7
	} ppc_mode_t;

	typedef struct packed {
		logic [15:0] in_alpha;
		logic [15:0] in_red;
		logic [15:0] in_green;
		logic [15:0] in_blue;
		logic [7:0]  back_red;
		logic [7:0]  back_green;
		logic [7:0]  back_blue;
		logic        in_last;
	} ppc_in_t;

	typedef struct packed {
		logic [15:0] out_first;
		logic [15:0] out_second;
		logic [15:0] out_third;
		logic [15:0] out_fourth;
		logic        out_last;
	} ppc_out_t;

	// per-channel division state plus side value for non-dividing modes
	typedef struct packed {
		logic [15:0]      rem;
		logic [15:0]      low;
		logic [15:0]      quo;
		logic             ovf;
		logic [AUX_W-1:0] aux;
	} ppc_chan_t;

	typedef struct packed {
		ppc_chan_t [2:0] ch;
		logic [15:0]     alpha;
		logic [15:0]     first;
		ppc_mode_t       mode;
		logic            last;
	} ppc_work_t;

	// byte to fixed point, (c << FRAC_BITS) / 255 truncated
	function automatic logic [255:0][15:0] widen_table();
		logic [255:0][15:0] t;
		for (int i = 0; i < 256; i++) begin
			t[i] = 16'((i * ONE_FIX) / 255);
		end
		return t;
	endfunction

	localparam logic [255:0][15:0] WIDEN_TAB = widen_table();

	function automatic logic [7:0] sat_byte(input logic [15:0] v);
		return (v > 16'(BYTE_MAX)) ? 8'(BYTE_MAX) : v[7:0];
	endfunction

endpackage

/* hw/rtl/ppc_front.sv */
module ppc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ppc_pkg::ppc_in_t   in_data,
	input  ppc_pkg::ppc_mode_t mode,
	output logic               out_valid,
	input  logic               out_ready,
	output ppc_pkg::ppc_work_t out_data
);
	import ppc_pkg::*;

	logic        valid_q;
	ppc_work_t   work_s1;
	ppc_work_t   work_d;
	logic [23:0] a_x255;
	logic [7:0]  a8;
	logic [15:0] alpha_fix;
	logic [15:0] oma;
	logic [15:0] comp [3];
	logic [7:0]  bg [3];
	logic [31:0] num [3];
	logic [7:0]  c8 [3];
	logic [23:0] c_x255 [3];

	assign comp[0] = in_data.in_red;
	assign comp[1] = in_data.in_green;
	assign comp[2] = in_data.in_blue;
	assign bg[0]   = in_data.back_red;
	assign bg[1]   = in_data.back_green;
	assign bg[2]   = in_data.back_blue;

	// alpha in the forms the modes need
	assign a_x255    = {in_data.in_alpha, 8'b0} - {8'b0, in_data.in_alpha};
	assign a8        = sat_byte({7'b0, a_x255[23:15]});
	assign alpha_fix = WIDEN_TAB[sat_byte(in_data.in_alpha)];
	assign oma       = (in_data.in_alpha > 16'(ONE_FIX)) ? 16'b0 :
		16'(ONE_FIX) - in_data.in_alpha;

	// per-channel setup: dividend, overflow check and side products
	always_comb begin
		work_d       = '0;
		work_d.alpha = in_data.in_alpha;
		work_d.mode  = mode;
		work_d.last  = in_data.in_last;
		for (int i = 0; i < 3; i++) begin
			num[i]    = (32'(comp[i]) << FRAC_BITS) + 32'(in_data.in_alpha[15:1]);
			c8[i]     = sat_byte(comp[i]);
			c_x255[i] = {comp[i], 8'b0} - {8'b0, comp[i]};
			work_d.ch[2-i].rem = num[i][31:16];
			work_d.ch[2-i].low = num[i][15:0];
			work_d.ch[2-i].ovf = (num[i][31:16] >= in_data.in_alpha);
			case (mode)
				MODE_PREMUL: work_d.ch[2-i].aux = AUX_W'(c8[i]) * AUX_W'(alpha_fix);
				MODE_WIDEN:  work_d.ch[2-i].aux = AUX_W'(WIDEN_TAB[c8[i]]);
				MODE_PAD:    work_d.ch[2-i].aux = AUX_W'(c8[i]);
				MODE_BLEND:  work_d.ch[2-i].aux = AUX_W'(c_x255[i]) +
					AUX_W'(oma) * AUX_W'(bg[i]);
				default:     work_d.ch[2-i].aux = '0;
			endcase
		end
		case (mode)
			MODE_ARGB8, MODE_RGBA8: work_d.first = {8'b0, a8};
			MODE_PREMUL:            work_d.first = alpha_fix;
			MODE_WIDEN:             work_d.first = 16'(ONE_FIX);
			MODE_PAD:               work_d.first = 16'(BYTE_MAX);
			default:                work_d.first = '0;
		endcase
	end

	// stage register
	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			work_s1 <= work_d;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = work_s1;

endmodule

/* hw/rtl/ppc_cell.sv */
module ppc_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ppc_pkg::ppc_work_t in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output ppc_pkg::ppc_work_t out_data
);
	import ppc_pkg::*;

	logic        valid_q;
	ppc_work_t   work_q;
	ppc_work_t   work_d;
	logic [16:0] r2 [3];
	logic        ge [3];

	// one restoring quotient bit for each channel
	always_comb begin
		work_d = in_data;
		for (int i = 0; i < 3; i++) begin
			r2[i] = {in_data.ch[i].rem, in_data.ch[i].low[15]};
			ge[i] = (r2[i] >= {1'b0, in_data.alpha});
			work_d.ch[i].rem = ge[i] ? 16'(r2[i] - {1'b0, in_data.alpha}) : r2[i][15:0];
			work_d.ch[i].low = {in_data.ch[i].low[14:0], 1'b0};
			work_d.ch[i].quo = {in_data.ch[i].quo[14:0], ge[i]};
		end
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			work_q <= work_d;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = work_q;

endmodule

/* hw/rtl/ppc_back.sv */
module ppc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ppc_pkg::ppc_work_t in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output ppc_pkg::ppc_out_t  out_data
);
	import ppc_pkg::*;

	logic        valid_q;
	ppc_out_t    res_q;
	ppc_out_t    res_d;
	logic [23:0] q_x255 [3];
	logic [47:0] prod [3];
	logic [15:0] unp [3];
	logic [15:0] pre [3];
	logic [15:0] bld [3];
	logic [15:0] side [3];

	// scale quotients, finish divide by 255, saturate blend
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			q_x255[i] = {in_data.ch[2-i].quo, 8'b0} - {8'b0, in_data.ch[2-i].quo};
			unp[i]    = in_data.ch[2-i].ovf ? 16'(BYTE_MAX) :
				{8'b0, sat_byte({7'b0, q_x255[i][23:15]})};
			prod[i]   = 48'(in_data.ch[2-i].aux[22:0]) * 48'(RECIP_255);
			pre[i]    = prod[i][RECIP_SHIFT +: 16];
			bld[i]    = {8'b0, sat_byte({6'b0, in_data.ch[2-i].aux[24:15]})};
			side[i]   = in_data.ch[2-i].aux[15:0];
		end
	end

	// channel order per mode
	always_comb begin
		res_d          = '0;
		res_d.out_last = in_data.last;
		case (in_data.mode)
			MODE_ARGB8: begin
				if (in_data.alpha != '0) begin
					res_d.out_first  = in_data.first;
					res_d.out_second = unp[0];
					res_d.out_third  = unp[1];
					res_d.out_fourth = unp[2];
				end
			end
			MODE_RGBA8, MODE_RGB8: begin
				if (in_data.alpha != '0) begin
					res_d.out_first  = unp[0];
					res_d.out_second = unp[1];
					res_d.out_third  = unp[2];
					res_d.out_fourth = (in_data.mode == MODE_RGBA8) ? in_data.first : '0;
				end
			end
			MODE_PREMUL: begin
				res_d.out_first  = in_data.first;
				res_d.out_second = pre[0];
				res_d.out_third  = pre[1];
				res_d.out_fourth = pre[2];
			end
			MODE_WIDEN, MODE_PAD: begin
				res_d.out_first  = in_data.first;
				res_d.out_second = side[0];
				res_d.out_third  = side[1];
				res_d.out_fourth = side[2];
			end
			MODE_BLEND: begin
				res_d.out_first  = bld[0];
				res_d.out_second = bld[1];
				res_d.out_third  = bld[2];
			end
			default: begin
				res_d.out_first = '0;
			end
		endcase
	end

	// output register
	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			res_q <= res_d;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = res_q;

endmodule

/* hw/rtl/premultiplied_pixel_converter_unit.sv */
// channel   direction  payload      handshake
// in        input      ppc_in_t     in_valid / in_stall
// out       output     ppc_out_t    out_valid / out_stall
// cfg       input      mode, 3 bit  cfg_we / cfg_data
//
// one pixel per clock sustained while out_stall is low; stages are a setup stage,
// 16 divider cells (one quotient bit each) and the output register
// every stage holds its own valid and moves into a free slot, so bubbles close up
// out_stall backs up stage by stage; in_stall rises once the whole row is full
// arst_n clears all stage valids and sets the mode to 0
module premultiplied_pixel_converter_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  ppc_pkg::ppc_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output ppc_pkg::ppc_out_t out_data,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_data
);
	import ppc_pkg::*;

	ppc_mode_t mode_q;
	logic      front_ready;
	ppc_work_t work  [NUM_CELLS+1];
	logic      wvalid[NUM_CELLS+1];
	logic      wready[NUM_CELLS+1];

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ARGB8;
		end else if (cfg_we) begin
			mode_q <= ppc_mode_t'(cfg_data);
		end
	end

	assign in_stall = !front_ready;

	ppc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (front_ready),
		.in_data   (in_data),
		.mode      (mode_q),
		.out_valid (wvalid[0]),
		.out_ready (wready[0]),
		.out_data  (work[0])
	);

	// row of divider cells
	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		ppc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (wvalid[i]),
			.in_ready  (wready[i]),
			.in_data   (work[i]),
			.out_valid (wvalid[i+1]),
			.out_ready (wready[i+1]),
			.out_data  (work[i+1])
		);
	end

	ppc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (wvalid[NUM_CELLS]),
		.in_ready  (wready[NUM_CELLS]),
		.in_data   (work[NUM_CELLS]),
		.out_valid (out_valid),
		.out_ready (!out_stall),
		.out_data  (out_data)
	);

endmodule

/* hw/rtl/ppc_checker.sv */
`include "premultiplied_pixel_converter_unit_assert.svh"

module ppc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input ppc_pkg::ppc_out_t out_data,
	input logic              cfg_we,
	input logic [2:0]        cfg_data
);
	import ppc_pkg::*;

	ppc_mode_t mode_q;
	logic      seen_q;
	logic      three_chan;

	// shadow of the mode and whether any transaction came in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ARGB8;
			seen_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= ppc_mode_t'(cfg_data);
			end
			if (in_valid && !in_stall) begin
				seen_q <= 1'b1;
			end
		end
	end

	// modes with only three output components
	assign three_chan = (mode_q == MODE_RGB8) || (mode_q == MODE_BLEND);

	`PPC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
	`PPC_ASSERT_NOW(a_no_phantom, out_valid, seen_q)
	`PPC_ASSERT_NOW(a_three_chan, out_valid && three_chan, out_data.out_fourth == '0)
	`PPC_ASSERT_NOW(a_pad_opaque, out_valid && mode_q == MODE_PAD, out_data.out_first == 16'(BYTE_MAX))

endmodule

bind premultiplied_pixel_converter_unit ppc_checker u_ppc_checker (.*);

/* bench/tb_premultiplied_pixel_converter_unit.sv */
module tb_premultiplied_pixel_converter_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import ppc_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int LATENCY      = 18;

	// expected pixel store and conversion predictor
	class pixel_scoreboard;
		ppc_mode_t mode;
		ppc_out_t  expected_pixels[$];
		int        errors;
		int        checked;

		function new();
			mode = MODE_ARGB8;
		endfunction

		function longint unsigned clip(longint unsigned v, longint unsigned top);
			return (v > top) ? top : v;
		endfunction

		function longint unsigned unpremultiply(longint unsigned c, longint unsigned a);
			longint unsigned q;
			q = ((c << FRAC_BITS) + a / 2) / a;
			return clip((q * 255) >> FRAC_BITS, 255);
		endfunction

		function longint unsigned over_back(longint unsigned c, longint unsigned oma,
				longint unsigned bg);
			return clip((c * 255 + oma * bg) >> FRAC_BITS, 255);
		endfunction

		function ppc_out_t convert(ppc_in_t x);
			longint unsigned a, r, g, b, a8, k, oma;
			longint unsigned o[4];
			ppc_out_t y;
			a = x.in_alpha;
			r = x.in_red;
			g = x.in_green;
			b = x.in_blue;
			o = '{0, 0, 0, 0};
			case (mode)
				MODE_ARGB8, MODE_RGBA8, MODE_RGB8: begin
					if (a != 0) begin
						a8 = clip((a * 255) >> FRAC_BITS, 255);
						if (mode == MODE_ARGB8) begin
							o = '{a8, unpremultiply(r, a), unpremultiply(g, a),
								unpremultiply(b, a)};
						end else begin
							o = '{unpremultiply(r, a), unpremultiply(g, a), unpremultiply(b, a),
								(mode == MODE_RGBA8) ? a8 : 64'd0};
						end
					end
				end
				MODE_PREMUL: begin
					k = clip((clip(a, 255) << FRAC_BITS) / 255, 16'hFFFF);
					o = '{k, clip(r, 255) * k / 255, clip(g, 255) * k / 255,
						clip(b, 255) * k / 255};
				end
				MODE_WIDEN: begin
					o = '{clip(ONE_FIX, 16'hFFFF),
						clip((clip(r, 255) << FRAC_BITS) / 255, 16'hFFFF),
						clip((clip(g, 255) << FRAC_BITS) / 255, 16'hFFFF),
						clip((clip(b, 255) << FRAC_BITS) / 255, 16'hFFFF)};
				end
				MODE_PAD: begin
					o = '{255, clip(r, 255), clip(g, 255), clip(b, 255)};
				end
				MODE_BLEND: begin
					oma = (a > ONE_FIX) ? 0 : ONE_FIX - a;
					o = '{over_back(r, oma, x.back_red), over_back(g, oma, x.back_green),
						over_back(b, oma, x.back_blue), 0};
				end
				default: begin
				end
			endcase
			y.out_first  = o[0][15:0];
			y.out_second = o[1][15:0];
			y.out_third  = o[2][15:0];
			y.out_fourth = o[3][15:0];
			y.out_last   = x.in_last;
			return y;
		endfunction

		function void note_pixel(ppc_in_t x);
			expected_pixels.push_back(convert(x));
		endfunction

		task report(string what, logic [15:0] got, logic [15:0] want);
			$display("mismatch on %s: got %0d, expected %0d", what, got, want);
			errors++;
		endtask

		task check_pixel(ppc_out_t y);
			ppc_out_t e;
			if (expected_pixels.size() == 0) begin
				report("unexpected pixel", y.out_first, 16'd0);
				return;
			end
			e = expected_pixels.pop_front();
			checked++;
			if (y.out_first !== e.out_first) report("out_first", y.out_first, e.out_first);
			if (y.out_second !== e.out_second) report("out_second", y.out_second, e.out_second);
			if (y.out_third !== e.out_third) report("out_third", y.out_third, e.out_third);
			if (y.out_fourth !== e.out_fourth) report("out_fourth", y.out_fourth, e.out_fourth);
			if (y.out_last !== e.out_last)
				report("out_last", 16'(y.out_last), 16'(e.out_last));
		endtask
	endclass

	logic       clk = 0;
	logic       arst_n = 0;
	logic       in_valid = 0;
	logic       in_stall;
	ppc_in_t    in_data = '0;
	logic       out_valid;
	logic       out_stall = 0;
	ppc_out_t   out_data;
	logic       cfg_we = 0;
	logic [2:0] cfg_data = '0;

	pixel_scoreboard sb = new();
	int  cycles = 0;
	int  sent = 0;
	bit  idle_en = 1;
	int  hold_cycles = 0;
	int  burst_left = 0;

	premultiplied_pixel_converter_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	// clock
	initial begin
		forever #6 clk = ~clk;
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("[premultiplied_pixel_converter_unit] ERROR");
			$finish;
		end
	end

	// receiver stall: long hold, random bursts, or none
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1;
			hold_cycles--;
		end else if (burst_left > 0) begin
			out_stall <= 1;
			burst_left--;
		end else if (idle_en && $urandom_range(0, 7) == 0) begin
			out_stall <= 1;
			burst_left = $urandom_range(1, 16) - 1;
		end else begin
			out_stall <= 0;
		end
	end

	// result transaction monitor, values are stable at the falling edge
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_pixel(out_data);
	end

	task send_pixel(ppc_in_t x);
		bit taken;
		if (idle_en && $urandom_range(0, 5) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1;
		in_data  <= x;
		taken = 0;
		while (!taken) begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end
		sb.note_pixel(x);
		sent++;
	endtask

	task drain();
		in_valid <= 0;
		while (sb.expected_pixels.size() > 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task write_mode(ppc_mode_t m);
		cfg_we   <= 1;
		cfg_data <= m;
		@(posedge clk);
		cfg_we <= 0;
		sb.mode = m;
	endtask

	function automatic ppc_in_t make_pixel(logic [15:0] a, logic [15:0] r, logic [15:0] g,
			logic [15:0] b, logic [7:0] br, logic [7:0] bgn, logic [7:0] bb, logic l);
		ppc_in_t x;
		x = '{a, r, g, b, br, bgn, bb, l};
		return x;
	endfunction

	// mostly well-formed pixels for the mode, sometimes any bits at all
	function automatic ppc_in_t random_pixel(ppc_mode_t m);
		ppc_in_t x;
		logic [15:0] a;
		logic [95:0] raw;
		raw = {$urandom, $urandom, $urandom};
		x = ppc_in_t'(raw[$bits(ppc_in_t)-1:0]);
		if ($urandom_range(0, 7) == 0) return x;
		if (m == MODE_PREMUL || m == MODE_WIDEN || m == MODE_PAD) begin
			x.in_alpha = 16'($urandom_range(0, 255));
			x.in_red   = 16'($urandom_range(0, 255));
			x.in_green = 16'($urandom_range(0, 255));
			x.in_blue  = 16'($urandom_range(0, 255));
		end else begin
			a = ($urandom_range(0, 9) == 0) ? 16'(ONE_FIX) : 16'($urandom_range(0, ONE_FIX));
			x.in_alpha = a;
			x.in_red   = 16'($urandom_range(0, a));
			x.in_green = 16'($urandom_range(0, a));
			x.in_blue  = 16'($urandom_range(0, a));
		end
		return x;
	endfunction

	initial begin
		ppc_mode_t m;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed corners under every mode, mode 0 from reset first
		for (int i = 0; i < 8; i++) begin
			m = ppc_mode_t'(i);
			if (i > 0) write_mode(m);
			send_pixel(make_pixel(16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0, 1'b0));
			send_pixel(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
				8'hFF, 8'hFF, 8'hFF, 1'b1));
			if (i == 3 || i == 4 || i == 5)
				send_pixel(make_pixel(16'd255, 16'd256, 16'd255, 16'd1, 8'd0, 8'd0, 8'd0, 1'b0));
			else
				send_pixel(make_pixel(16'd32768, 16'd32768, 16'd1, 16'd0,
					8'd255, 8'd0, 8'd128, 1'b1));
			drain();
		end

		// random phases through every mode; the last phase runs without idling
		for (int p = 0; p < 12; p++) begin
			m = (p < 8) ? ppc_mode_t'(p) : ppc_mode_t'($urandom_range(0, 7));
			if (p == 11) m = MODE_BLEND;
			idle_en = (p % 4 != 3) && (p != 11);
			write_mode(m);
			for (int k = 0; k < 140; k++) begin
				if (p == 5 && k == 20) hold_cycles = 300;
				send_pixel(random_pixel(m));
			end
			drain();
		end

		$display("%0d pixels sent, %0d results checked across all eight modes,",
			sent, sb.checked);
		$display("with random stalls, a long output hold and idle-free stretches");
		if (sb.errors == 0 && sb.expected_pixels.size() == 0) begin
			$display("[premultiplied_pixel_converter_unit] OK");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.errors,
				sb.expected_pixels.size());
			$display("[premultiplied_pixel_converter_unit] ERROR");
		end
		$finish;
	end

endmodule

/* premultiplied_pixel_converter_unit.f */
+incdir+hw/rtl
hw/rtl/ppc_pkg.sv
hw/rtl/ppc_front.sv
hw/rtl/ppc_cell.sv
hw/rtl/ppc_back.sv
hw/rtl/premultiplied_pixel_converter_unit.sv
hw/rtl/ppc_checker.sv
bench/tb_premultiplied_pixel_converter_unit.sv
